FILE: src/i2cms_pkg.sv
package i2cms_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ACT_ADDR    = 4'd0,
        ACT_DATA    = 4'd1,
        ACT_STOP    = 4'd2,
        ACT_REP     = 4'd3,
        ACT_RESTART = 4'd4,
        ACT_RX_ACK  = 4'd5,
        ACT_RX_NACK = 4'd6,
        ACT_FINISH  = 4'd7,
        ACT_NONE    = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        NOTIFY_NEVER = 2'd0,
        NOTIFY_READ  = 2'd1,
        NOTIFY_WRITE = 2'd2,
        NOTIFY_ALWAYS = 2'd3
    } notify_mode_t;

    // Controller status codes.
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_REP_START  = 8'h10;
    localparam logic [7:0] ST_AW_ACK     = 8'h18;
    localparam logic [7:0] ST_AW_NACK    = 8'h20;
    localparam logic [7:0] ST_DW_ACK     = 8'h28;
    localparam logic [7:0] ST_DW_NACK    = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_AR_ACK     = 8'h40;
    localparam logic [7:0] ST_AR_NACK    = 8'h48;
    localparam logic [7:0] ST_DR_ACK     = 8'h50;
    localparam logic [7:0] ST_DR_NACK    = 8'h58;

    // Direction bit of the address byte.
    localparam logic [7:0] ADDR_READ_BIT = 8'h01;

endpackage

FILE: src/i2cms_buffer.sv
module i2cms_buffer #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while re is low, so a stalled result keeps its byte.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/i2c_master_status_sequencer.sv
// I2C master transaction sequencer driven by controller status codes.
// Input channel (in_valid/in_ready) carries one command per transfer: load a
// transaction, write a buffer byte, report a controller status event, or read
// a buffer byte. Output channel (out_valid/out_ready) returns exactly one
// result per command: the bus action, the byte for the data register, the
// completion flag with final status and notify flag, and the buffer byte.
// A result is presented the cycle after its command is taken. One command is
// accepted per cycle unless the output stalls; the byte buffer is a single
// synchronous RAM with one write and one read port, written in the accept
// cycle, so a read in the next command already sees the new byte.
// The transaction registers and byte counter are updated in the accept cycle,
// which lets back-to-back events follow each other without a bubble.
// Reset clears the transaction registers and leaves the block idle; buffer
// contents are undefined until written.
// When the receiver stalls, the result register holds and in_ready stays low
// until out_ready rises; in_ready follows out_ready in the same cycle.
module i2c_master_status_sequencer #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] address_byte,
    input  logic [4:0] transfer_length,
    input  logic       repeat_start,
    input  logic [1:0] notify_mode,
    input  logic [3:0] byte_index,
    input  logic [7:0] data_byte,
    input  logic [7:0] status_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] bus_action,
    output logic [7:0] tx_byte,
    output logic       done_res,
    output logic [7:0] final_status,
    output logic       notify,
    output logic [7:0] read_byte
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    // Transaction state.
    logic [7:0]    slave_address_reg, slave_address_next;
    logic [4:0]    length_reg, length_next;
    logic          repeat_reg, repeat_next;
    logic [1:0]    notify_mode_reg, notify_mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic          active_reg, active_next;

    // Result register.
    logic                    out_valid_reg;
    i2cms_pkg::action_t      act_reg, act_next;
    logic [7:0]              tx_reg, tx_next;
    logic                    tx_mem_reg, tx_mem_next;
    logic                    rd_mem_reg, rd_mem_next;
    logic                    done_reg, done_next;
    logic [7:0]              final_reg, final_next;
    logic                    notify_reg, notify_next;

    logic          in_fire;
    logic          buf_we;
    logic [AW-1:0] buf_waddr;
    logic [AW-1:0] buf_raddr;
    logic [AW-1:0] idx_addr;
    logic [AW-1:0] cnt_addr;
    logic [7:0]    buf_rdata;
    logic          idx_ok;
    logic          cnt_below;
    logic [CW-1:0] cnt_inc;
    logic          want_notify;
    logic          is_read_xfer;
    logic [31:0]   idx_ext;
    i2cms_pkg::action_t end_act;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign idx_ext   = 32'(byte_index);
    assign idx_addr  = idx_ext[AW-1:0];
    assign cnt_addr  = count_reg[AW-1:0];
    assign idx_ok    = idx_ext < 32'(BUFFER_DEPTH);
    assign cnt_below = 32'(count_reg) < 32'(BUFFER_DEPTH);
    assign cnt_inc   = cnt_below ? count_reg + CW'(1) : count_reg;
    assign end_act   = repeat_reg ? i2cms_pkg::ACT_REP : i2cms_pkg::ACT_STOP;

    assign is_read_xfer = (slave_address_reg & i2cms_pkg::ADDR_READ_BIT) != 8'd0;

    always_comb
    begin
        case (notify_mode_reg)
            i2cms_pkg::NOTIFY_ALWAYS: want_notify = 1'b1;
            i2cms_pkg::NOTIFY_READ:   want_notify = is_read_xfer;
            i2cms_pkg::NOTIFY_WRITE:  want_notify = !is_read_xfer;
            default:                  want_notify = 1'b0;
        endcase
    end

    always_comb
    begin
        slave_address_next = slave_address_reg;
        length_next        = length_reg;
        repeat_next        = repeat_reg;
        notify_mode_next   = notify_mode_reg;
        count_next         = count_reg;
        active_next        = active_reg;
        act_next           = i2cms_pkg::ACT_NONE;
        tx_next            = 8'd0;
        tx_mem_next        = 1'b0;
        rd_mem_next        = 1'b0;
        done_next          = 1'b0;
        final_next         = 8'd0;
        notify_next        = 1'b0;
        buf_we             = 1'b0;
        buf_waddr          = cnt_addr;
        buf_raddr          = cnt_addr;

        case (cmd)
            i2cms_pkg::CMD_LOAD:
            begin
                slave_address_next = address_byte;
                length_next        = transfer_length;
                repeat_next        = repeat_start;
                notify_mode_next   = notify_mode;
                count_next         = '0;
                active_next        = 1'b1;
            end
            i2cms_pkg::CMD_WRITE:
            begin
                buf_we    = idx_ok;
                buf_waddr = idx_addr;
            end
            i2cms_pkg::CMD_READ:
            begin
                buf_raddr   = idx_addr;
                rd_mem_next = idx_ok;
            end
            default:
            begin
                if (active_reg)
                begin
                    case (status_code) inside
                        i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START:
                        begin
                            act_next = i2cms_pkg::ACT_ADDR;
                            tx_next  = slave_address_reg;
                        end
                        i2cms_pkg::ST_AW_ACK, i2cms_pkg::ST_DW_ACK:
                        begin
                            if (32'(count_reg) == 32'(length_reg))
                            begin
                                act_next    = end_act;
                                done_next   = 1'b1;
                                final_next  = status_code;
                                notify_next = want_notify;
                                active_next = 1'b0;
                            end
                            else
                            begin
                                // A counter parked at the buffer depth sends zero.
                                act_next    = i2cms_pkg::ACT_DATA;
                                tx_mem_next = cnt_below;
                                count_next  = cnt_inc;
                            end
                        end
                        i2cms_pkg::ST_AW_NACK, i2cms_pkg::ST_DW_NACK,
                        i2cms_pkg::ST_AR_NACK:
                        begin
                            act_next    = i2cms_pkg::ACT_STOP;
                            done_next   = 1'b1;
                            final_next  = status_code;
                            notify_next = want_notify;
                            active_next = 1'b0;
                        end
                        i2cms_pkg::ST_ARB_LOST:
                        begin
                            act_next = i2cms_pkg::ACT_RESTART;
                        end
                        i2cms_pkg::ST_AR_ACK:
                        begin
                            act_next = (32'(length_reg) <= 32'(count_reg) + 32'd1) ?
                                       i2cms_pkg::ACT_RX_NACK : i2cms_pkg::ACT_RX_ACK;
                        end
                        i2cms_pkg::ST_DR_ACK:
                        begin
                            buf_we     = cnt_below;
                            count_next = cnt_inc;
                            act_next   = (32'(length_reg) == 32'(cnt_inc) + 32'd1) ?
                                         i2cms_pkg::ACT_RX_NACK : i2cms_pkg::ACT_RX_ACK;
                        end
                        i2cms_pkg::ST_DR_NACK:
                        begin
                            buf_we      = cnt_below;
                            act_next    = end_act;
                            done_next   = 1'b1;
                            final_next  = status_code;
                            notify_next = want_notify;
                            active_next = 1'b0;
                        end
                        default:
                        begin
                            act_next    = i2cms_pkg::ACT_FINISH;
                            done_next   = 1'b1;
                            final_next  = status_code;
                            notify_next = want_notify;
                            active_next = 1'b0;
                        end
                    endcase
                end
            end
        endcase
    end

    i2cms_buffer #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_buffer (
        .clk   (clk),
        .we    (buf_we && in_fire),
        .waddr (buf_waddr),
        .wdata (data_byte),
        .re    (in_fire),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd0;
            length_reg        <= 5'd0;
            repeat_reg        <= 1'b0;
            notify_mode_reg   <= 2'd0;
            count_reg         <= '0;
            active_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                slave_address_reg <= slave_address_next;
                length_reg        <= length_next;
                repeat_reg        <= repeat_next;
                notify_mode_reg   <= notify_mode_next;
                count_reg         <= count_next;
                active_reg        <= active_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg    <= act_next;
            tx_reg     <= tx_next;
            tx_mem_reg <= tx_mem_next;
            rd_mem_reg <= rd_mem_next;
            done_reg   <= done_next;
            final_reg  <= final_next;
            notify_reg <= notify_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bus_action   = act_reg;
    assign tx_byte      = tx_mem_reg ? buf_rdata : tx_reg;
    assign done_res     = done_reg;
    assign final_status = final_reg;
    assign notify       = notify_reg;
    assign read_byte    = rd_mem_reg ? buf_rdata : 8'd0;

endmodule
